### rtl/core/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg
// Shared codes for the postfix expression evaluator: symbols, status codes
// and the arithmetic unit's operation select and handshake structs.
// ----------------------------------------------------------------------------
package pec_pkg;

	localparam logic [7:0] SYM_ADD  = 8'h2B;	// '+'
	localparam logic [7:0] SYM_SUB  = 8'h2D;	// '-'
	localparam logic [7:0] SYM_MUL  = 8'h2A;	// '*'
	localparam logic [7:0] SYM_DIV  = 8'h2F;	// '/'
	localparam logic [31:0] DIGIT_BIAS = 32'd48;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic divz;
	} alu_rsp_t;

endpackage

### rtl/core/pec_stack.sv
// ----------------------------------------------------------------------------
// pec_stack
// Operand stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pec_stack #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/pec_alu.sv
// ----------------------------------------------------------------------------
// pec_alu
// Shared arithmetic unit: add, subtract and multiply with a registered result,
// signed truncating divide by a restoring loop, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pec_alu
	import pec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output alu_rsp_t    rsp,
	output logic [31:0] result
);

	typedef enum logic [1:0] {
		A_IDLE,
		A_DIV,
		A_FIX
	} astate_t;

	astate_t     state_q;
	logic [4:0]  step_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_b_q;
	logic        neg_q;
	logic        done_q;
	logic        divz_q;
	logic [31:0] result_q;

	logic [31:0] mag_a;
	logic [31:0] mag_b;
	logic [32:0] shifted;
	logic [32:0] trial;

	assign mag_a   = a[31] ? (32'd0 - a) : a;
	assign mag_b   = b[31] ? (32'd0 - b) : b;
	assign shifted = {rem_q[31:0], quo_q[31]};
	assign trial   = shifted - {1'b0, div_b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			divz_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						divz_q <= 1'b0;
						case (req.op)
							ALU_ADD: begin
								result_q <= a + b;
								done_q   <= 1'b1;
							end
							ALU_SUB: begin
								result_q <= a - b;
								done_q   <= 1'b1;
							end
							ALU_MUL: begin
								result_q <= a * b;
								done_q   <= 1'b1;
							end
							default: begin
								if (b == 32'd0) begin
									result_q <= 32'd0;
									divz_q   <= 1'b1;
									done_q   <= 1'b1;
								end else begin
									rem_q   <= 33'd0;
									quo_q   <= mag_a;
									div_b_q <= mag_b;
									neg_q   <= a[31] ^ b[31];
									step_q  <= 5'd0;
									state_q <= A_DIV;
								end
							end
						endcase
					end
				end
				A_DIV: begin
					if (!trial[32]) begin
						rem_q <= trial;
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= shifted;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					result_q <= neg_q ? (32'd0 - quo_q) : quo_q;
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.divz = divz_q;
	assign result   = result_q;

endmodule

### rtl/core/postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Postfix (RPN) evaluator over a bounded 32-bit operand stack, with a shared
// arithmetic unit driven by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------
//  input   | in_valid / in_ready  | symbol[7:0], end_of_expr
//  output  | out_valid / out_ready| value[31:0] (signed), status[1:0],
//          |                      | leftover[4:0]
//
//  Digit word: accept, then push.
//  Operator + - *: accept, pop right, pop left, launch the unit, wait, push; /
//  waits on the one-bit-per-cycle divide loop in the shared arithmetic unit.
//  End-of-expression word: the final pop and the output load follow its push.
//  Reset clears the sequencer, stack count and sticky status; no clearing pass.
//  in_ready is low while a word is being worked on; a result that is not taken
//  holds only the final load of the next end-of-expression word.
//
module postfix_expression_evaluator_unit
	import pec_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         symbol,
	input  logic               end_of_expr,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [1:0]         status,
	output logic [4:0]         leftover
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RHS,		// pop right operand
		S_LHS,		// take right operand, pop left operand
		S_ALU,		// launch shared unit
		S_WAIT,		// wait for the unit
		S_PUSH,		// push result or digit
		S_FIN_RD,	// final pop
		S_FIN_LD	// load output word, clear stack
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [1:0]    sticky_q;
	logic          last_q;
	alu_op_t       op_q;
	logic [31:0]   push_q;
	logic [31:0]   rhs_q;
	logic          rhs_mem_q;	// right operand comes from the read port
	logic          lhs_mem_q;
	logic          fin_mem_q;

	logic          out_valid_q;
	logic [31:0]   value_q;
	logic [1:0]    status_q;
	logic [4:0]    leftover_q;

	logic          is_op;
	alu_op_t       dec_op;
	logic          empty;
	logic [AW-1:0] top_addr;

	logic          rd_en;
	logic          wr_en;
	logic [31:0]   rd_data;

	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;
	logic [31:0]   alu_result;
	logic [31:0]   lhs_val;
	logic [31:0]   cnt_ext;

	// first error wins
	function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	always_comb begin
		is_op  = 1'b1;
		dec_op = ALU_ADD;
		case (symbol)
			SYM_ADD: dec_op = ALU_ADD;
			SYM_SUB: dec_op = ALU_SUB;
			SYM_MUL: dec_op = ALU_MUL;
			SYM_DIV: dec_op = ALU_DIV;
			default: is_op = 1'b0;
		endcase
	end

	assign empty    = (count_q == '0);
	assign top_addr = AW'(count_q - CW'(1));
	assign in_ready = (state_q == S_IDLE);

	assign rd_en = ((state_q == S_RHS) || (state_q == S_LHS) || (state_q == S_FIN_RD))
		&& !empty;
	assign wr_en = (state_q == S_PUSH) && (count_q < DEPTH_C);

	// popped left operand: read data, or -1 after an underflow
	assign lhs_val     = lhs_mem_q ? rd_data : 32'hFFFF_FFFF;
	assign alu_req.start = (state_q == S_ALU);
	assign alu_req.op    = op_q;
	assign cnt_ext     = 32'(count_q);

	pec_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(count_q)),
		.wr_data (push_q),
		.rd_en   (rd_en),
		.rd_addr (top_addr),
		.rd_data (rd_data)
	);

	pec_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (lhs_val),
		.b      (rhs_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sticky_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// final load handles its own output handoff
			if (out_valid_q && out_ready && (state_q != S_FIN_LD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= end_of_expr;
						op_q   <= dec_op;
						push_q <= 32'(symbol) - DIGIT_BIAS;
						state_q <= is_op ? S_RHS : S_PUSH;
					end
				end
				S_RHS: begin
					rhs_mem_q <= !empty;
					if (empty) begin
						sticky_q <= note_err(sticky_q, ST_UNDER);
					end else begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_LHS;
				end
				S_LHS: begin
					rhs_q     <= rhs_mem_q ? rd_data : 32'hFFFF_FFFF;
					lhs_mem_q <= !empty;
					if (empty) begin
						sticky_q <= note_err(sticky_q, ST_UNDER);
					end else begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_ALU;
				end
				S_ALU: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						push_q <= alu_result;
						if (alu_rsp.divz) begin
							sticky_q <= note_err(sticky_q, ST_DIVZ);
						end
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (count_q < DEPTH_C) begin
						count_q <= count_q + CW'(1);
					end else begin
						sticky_q <= note_err(sticky_q, ST_OVER);
					end
					state_q <= last_q ? S_FIN_RD : S_IDLE;
				end
				S_FIN_RD: begin
					fin_mem_q <= !empty;
					if (empty) begin
						sticky_q <= note_err(sticky_q, ST_UNDER);
					end else begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_FIN_LD;
				end
				S_FIN_LD: begin
					// wait for the output register to free up
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						value_q     <= fin_mem_q ? rd_data : 32'hFFFF_FFFF;
						status_q    <= sticky_q;
						leftover_q  <= (cnt_ext > 32'd31) ? 5'd31 : cnt_ext[4:0];
						count_q     <= '0;
						sticky_q    <= ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value     = signed'(value_q);
	assign status    = status_q;
	assign leftover  = leftover_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count beyond depth");

	a_alu_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_WAIT)
		else $error("arithmetic unit done outside wait state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != S_IDLE)
		else $error("sequencer idle after accepting a word");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_FIN_LD)
		else $error("output word loaded outside final load");
`endif

endmodule
